>>> rtl/core/rqs_pkg.sv
// Package: shared constants and types for the ready-queue scheduler.
`timescale 1ns / 1ps
package rqs_pkg;
    localparam int RING_DEPTH_DEF = 16;

    localparam logic [1:0] KIND_ADMIT = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_SCHED = 2'd2;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;

    localparam logic [2:0] ST_ADMITTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_SET      = 3'd2;
    localparam logic [2:0] ST_SWITCHED = 3'd3;
    localparam logic [2:0] ST_KEPT     = 3'd4;
    localparam logic [2:0] ST_NONE     = 3'd5;

    localparam logic [31:0] RANK_MAX = 32'hFFFF_FFFF;

    localparam logic [1:0] ADDR_POLICY  = 2'd0;
    localparam logic [1:0] ADDR_QUANTUM = 2'd1;

    // Compare-unit operation codes.
    localparam logic [1:0] CMP_ELAPSED = 2'd0;
    localparam logic [1:0] CMP_AVG     = 2'd1;
    localparam logic [1:0] CMP_RANK    = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] res;
        logic        lt;
    } t_alu_rsp;
endpackage

>>> rtl/core/rqs_alu.sv
// Shared arithmetic unit: elapsed time, burst average and SJF rank compare.
`timescale 1ns / 1ps
module rqs_alu
    import rqs_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);
    logic [32:0] sum;
    logic [31:0] diff;
    logic [31:0] ra;
    logic [31:0] rb;

    always_comb begin
        sum   = {1'b0, i_req.a} + {1'b0, i_req.b};
        diff  = i_req.a - i_req.b;
        ra    = (i_req.a == 32'd0) ? RANK_MAX : i_req.a;
        rb    = (i_req.b == 32'd0) ? RANK_MAX : i_req.b;
        o_rsp = '0;
        case (i_req.op)
            CMP_ELAPSED: begin
                // a = now, b = dispatch tick
                o_rsp.res = (i_req.a < i_req.b || diff == 32'd0) ? 32'd1 : diff;
            end
            CMP_AVG: begin
                // a = old prediction, b = elapsed (>= 1)
                if (i_req.a == 32'd0) begin
                    o_rsp.res = i_req.b;
                end else begin
                    o_rsp.res = (sum[32:1] == 32'd0) ? 32'd1 : sum[32:1];
                end
            end
            CMP_RANK: begin
                o_rsp.lt = ra < rb;
            end
            default: o_rsp = '0;
        endcase
    end
endmodule

>>> rtl/core/ready_queue_scheduler_fcfs_rr_sjf_core.sv
// Top level: ready-queue scheduler with FCFS, SJF and round-robin dispatch.
// Sequencing: admit, set and trivial items go from idle to output; a schedule
// event that may switch runs elapsed and average on requeue, then pick; SJF
// adds an entry scan and a shift, all sequenced over one compare unit.
// Throughput: one item at a time; ready is low until the result is taken.
// Reset (synchronous, active low) clears ring pointers, running task, dispatch tick.
`timescale 1ns / 1ps
module ready_queue_scheduler_fcfs_rr_sjf_core
    import rqs_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [15:0] task_id, [47:16] burst_hint, [79:48] now_tick, [80] requeue
    input  logic [87:0] s_axis_tdata,
    // tuser: [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [15:0] running_id, [31:16] previous_id, [36:32] ready_count
    output logic [39:0] m_axis_tdata,
    // tuser: [2:0] status
    output logic [2:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = CW + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ELAP  = 7'b0000010,
        S_AVG   = 7'b0000100,
        S_PICK  = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_SHIFT = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;

    // Ring storage: no reset, only entries below occupancy are read.
    logic [15:0] r_ids [RING_DEPTH];
    logic [31:0] r_bursts [RING_DEPTH];

    logic [IW-1:0] r_head, r_tail;
    logic [CW-1:0] r_occ;
    logic          r_run_valid;
    logic [15:0]   r_run_task;
    logic [31:0]   r_run_burst;
    logic [31:0]   r_disp_tick;
    logic [15:0]   r_ticks_left;
    logic [1:0]    r_policy;
    logic [15:0]   r_quantum;

    // Item and sequencer registers.
    logic [31:0]   r_now;
    logic [31:0]   r_elapsed;
    logic [CW-1:0] r_i;       // scan / shift offset from head
    logic [CW-1:0] r_best;
    logic [31:0]   r_best_burst;
    logic [2:0]    r_status;
    logic [15:0]   r_prev;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    rqs_alu u_alu (.i_req(alu_req), .o_rsp(alu_rsp));

    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    logic [IW-1:0] scan_idx, shd, shs, best_idx, tail_dec;
    logic [15:0]   q_wr;

    // Ring position base + off, wrapped at the ring depth (off at most the depth).
    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(RING_DEPTH)) sum = sum - SW'(RING_DEPTH);
        return sum[IW-1:0];
    endfunction

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    // Registers sit on word addresses: the word index is paddr[2].
    assign cfg_idx = {1'b0, paddr[2]};
    assign q_wr    = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];

    always_comb begin
        case (cfg_idx)
            ADDR_POLICY:  prdata = {30'd0, r_policy};
            ADDR_QUANTUM: prdata = {16'd0, r_quantum};
            default:      prdata = 32'd0;
        endcase
    end

    assign scan_idx = ring_add(r_head, r_i);
    assign shd      = ring_add(r_head, r_i);
    assign shs      = ring_add(r_head, r_i + CW'(1));
    assign best_idx = ring_add(r_head, r_best);
    assign tail_dec = (r_tail == '0) ? IW'(RING_DEPTH - 1) : r_tail - IW'(1);

    always_comb begin
        alu_req = '0;
        case (r_state)
            S_ELAP:  begin
                alu_req.op = CMP_ELAPSED; alu_req.a = r_now; alu_req.b = r_disp_tick;
            end
            S_AVG:   begin
                alu_req.op = CMP_AVG; alu_req.a = r_run_burst; alu_req.b = r_elapsed;
            end
            S_SCAN:  begin alu_req.op = CMP_RANK; alu_req.a = r_bursts[scan_idx];
                     alu_req.b = r_best_burst; end
            default: alu_req = '0;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {3'd0, 5'(r_occ), r_prev, (r_run_valid ? r_run_task : 16'd0)};

    // Ring memory writes: admit/requeue at tail, SJF shift.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid && s_axis_tuser == KIND_ADMIT
            && r_occ < CW'(RING_DEPTH)) begin
            r_ids[r_tail]    <= s_axis_tdata[15:0];
            r_bursts[r_tail] <= s_axis_tdata[47:16];
        end else if (r_state == S_AVG && r_occ < CW'(RING_DEPTH)) begin
            r_ids[r_tail]    <= r_run_task;
            r_bursts[r_tail] <= alu_rsp.res;
        end else if (r_state == S_SHIFT && r_i + CW'(1) < r_occ) begin
            r_ids[shd]    <= r_ids[shs];
            r_bursts[shd] <= r_bursts[shs];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_occ        <= '0;
            r_run_valid  <= 1'b0;
            r_run_task   <= '0;
            r_run_burst  <= '0;
            r_disp_tick  <= '0;
            r_ticks_left <= 16'd1;
            r_policy     <= POL_FCFS;
            r_quantum    <= 16'd1;
            r_status     <= ST_NONE;
        end else begin
            if (cfg_wr && cfg_idx == ADDR_POLICY) r_policy <= pwdata[1:0];
            if (cfg_wr && cfg_idx == ADDR_QUANTUM) begin
                r_quantum    <= q_wr;
                r_ticks_left <= q_wr;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_prev <= r_run_valid ? r_run_task : 16'd0;
                        r_now  <= s_axis_tdata[79:48];
                        r_state <= S_OUT;
                        case (s_axis_tuser)
                            KIND_ADMIT: begin
                                if (r_occ < CW'(RING_DEPTH)) begin
                                    r_tail   <= ring_add(r_tail, CW'(1));
                                    r_occ    <= r_occ + CW'(1);
                                    r_status <= ST_ADMITTED;
                                end else begin
                                    r_status <= ST_FULL;
                                end
                            end
                            KIND_SET: begin
                                r_run_task  <= s_axis_tdata[15:0];
                                r_run_burst <= s_axis_tdata[47:16];
                                r_disp_tick <= s_axis_tdata[79:48];
                                r_run_valid <= 1'b1;
                                r_status    <= ST_SET;
                            end
                            KIND_SCHED: begin
                                if (!r_run_valid) begin
                                    r_status <= ST_NONE;
                                end else if (r_policy == POL_RR && s_axis_tdata[80]
                                             && r_ticks_left > 16'd1) begin
                                    r_ticks_left <= r_ticks_left - 16'd1;
                                    r_status     <= ST_KEPT;
                                end else begin
                                    if (r_policy == POL_RR && s_axis_tdata[80])
                                        r_ticks_left <= r_quantum;
                                    r_status <= ST_KEPT;
                                    r_state  <= s_axis_tdata[80] ? S_ELAP : S_PICK;
                                end
                            end
                            default: r_status <= r_run_valid ? ST_KEPT : ST_NONE;
                        endcase
                    end
                end
                S_ELAP: begin
                    r_elapsed <= alu_rsp.res;
                    r_state   <= S_AVG;
                end
                S_AVG: begin
                    r_run_burst <= alu_rsp.res;
                    if (r_occ < CW'(RING_DEPTH)) begin
                        r_tail  <= ring_add(r_tail, CW'(1));
                        r_occ   <= r_occ + CW'(1);
                        r_state <= S_PICK;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_PICK: begin
                    if (r_occ == '0) begin
                        r_state <= S_OUT;
                    end else if (r_policy == POL_SJF) begin
                        r_best       <= '0;
                        r_best_burst <= r_bursts[r_head];
                        r_i          <= CW'(1);
                        r_state      <= S_SCAN;
                    end else begin
                        r_run_task  <= r_ids[r_head];
                        r_run_burst <= r_bursts[r_head];
                        r_disp_tick <= r_now;
                        r_head      <= ring_add(r_head, CW'(1));
                        r_occ       <= r_occ - CW'(1);
                        if (r_policy == POL_RR) r_ticks_left <= r_quantum;
                        r_status    <= ST_SWITCHED;
                        r_state     <= S_OUT;
                    end
                end
                S_SCAN: begin
                    if (r_i >= r_occ) begin
                        // Take the chosen entry, then close the gap behind it.
                        r_run_task  <= r_ids[best_idx];
                        r_run_burst <= r_bursts[best_idx];
                        r_disp_tick <= r_now;
                        r_i         <= r_best;
                        r_state     <= S_SHIFT;
                    end else begin
                        if (alu_rsp.lt) begin
                            r_best       <= r_i;
                            r_best_burst <= r_bursts[scan_idx];
                        end
                        r_i <= r_i + CW'(1);
                    end
                end
                S_SHIFT: begin
                    if (r_i + CW'(1) < r_occ) begin
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_tail   <= tail_dec;
                        r_occ    <= r_occ - CW'(1);
                        r_status <= ST_SWITCHED;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Occupancy never exceeds the ring depth.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(RING_DEPTH)) else $error("occupancy overflow");
    // Ring pointers stay consistent with occupancy.
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> ring_add(r_head, r_occ) == r_tail)
        else $error("ring pointers disagree with occupancy");
    // A switch always leaves a running task.
    a_sw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_status == ST_SWITCHED) |-> r_run_valid)
        else $error("switch without running task");
    // Ticks left never reach zero.
    a_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ticks_left != 16'd0) else $error("ticks_left zero");
endmodule
